// ----- rtl/arrs_pkg.sv -----
// Package for the aligned read request splitter: sizes, limits, sequencer
// states and the packed word types used by the modules. No dependencies.
package arrs_pkg;

  localparam int ALIGN_UNIT  = 32;
  localparam int ALIGN_W     = $clog2(ALIGN_UNIT);
  localparam int MAX_CHUNK   = 2048;
  localparam int MAX_REQUEST = 126976;

  localparam int OFF_W  = 33;
  localparam int CNT_W  = 20;
  localparam int LEN_W  = 12;
  localparam int FROM_W = 5;
  localparam int DEST_W = 17;
  localparam int LEFT_W = $clog2(MAX_REQUEST + 1);

  localparam logic [OFF_W-1:0] SMALL_LIMIT = 33'h0_5705_7C00;
  localparam logic [OFF_W-1:0] LARGE_LIMIT = 33'h1_1824_4F00;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ERR,
    ST_SINGLE,
    ST_HEAD,
    ST_BODY
  } arrs_state_t;

  typedef struct packed {
    logic [OFF_W-1:0] byte_offset;
    logic [CNT_W-1:0] byte_count;
  } arrs_in_t;

  typedef struct packed {
    logic [OFF_W-1:0]  chunk_offset;
    logic [LEN_W-1:0]  chunk_length;
    logic [FROM_W-1:0] copy_from;
    logic [LEN_W-1:0]  copy_count;
    logic [DEST_W-1:0] dest_offset;
    logic              too_long;
    logic              last;
  } arrs_cmd_t;

  typedef struct packed {
    logic [OFF_W-1:0]  chunk_offset;
    logic [LEN_W-1:0]  chunk_length;
    logic              issue_read;
    logic              in_range;
    logic [FROM_W-1:0] copy_from;
    logic [LEN_W-1:0]  copy_count;
    logic [DEST_W-1:0] dest_offset;
    logic              too_long;
    logic              last;
  } arrs_out_t;

endpackage

// ----- rtl/arrs_cmd_gen.sv -----
// Command sequencer: walks one request through error, single, head and
// chunk commands with a shared offset/remaining/destination step. Depends on arrs_pkg.
module arrs_cmd_gen import arrs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  arrs_in_t  req,
  input  logic      advance,
  output logic      busy,
  output arrs_cmd_t cmd
);

  arrs_state_t       state_r, state_nxt;
  logic [OFF_W-1:0]  cur_r, cur_nxt;
  logic [LEFT_W-1:0] left_r, left_nxt;
  logic [DEST_W-1:0] dest_r, dest_nxt;

  logic              req_too_long;
  logic              req_aligned;
  logic [LEFT_W-1:0] head_j;
  logic [LEFT_W-1:0] head_room;
  logic [LEFT_W-1:0] step_amt;
  logic [OFF_W-1:0]  cur_sum;
  logic [LEFT_W-1:0] left_rem;
  logic [DEST_W-1:0] dest_sum;

  assign req_too_long = req.byte_count > CNT_W'(MAX_REQUEST);
  assign req_aligned  = (req.byte_offset[ALIGN_W-1:0] == '0) &&
                        (req.byte_count[ALIGN_W-1:0] == '0) &&
                        (req.byte_count <= CNT_W'(MAX_CHUNK));

  assign head_j    = LEFT_W'(cur_r[ALIGN_W-1:0]);
  assign head_room = LEFT_W'(ALIGN_UNIT) - head_j;

  // The head copies up to the next alignment boundary; every later
  // command takes at most one full chunk.
  always_comb begin
    if (state_r == ST_HEAD) begin
      step_amt = (head_room > left_r) ? left_r : head_room;
    end else begin
      step_amt = (left_r > LEFT_W'(MAX_CHUNK)) ? LEFT_W'(MAX_CHUNK) : left_r;
    end
  end

  assign cur_sum  = cur_r + OFF_W'(step_amt);
  assign left_rem = left_r - step_amt;
  assign dest_sum = dest_r + DEST_W'(step_amt);

  assign busy = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    left_r <= left_nxt;
    dest_r <= dest_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    left_nxt  = left_r;
    dest_nxt  = dest_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (load) begin
          cur_nxt  = req.byte_offset;
          left_nxt = LEFT_W'(req.byte_count);
          dest_nxt = '0;
          if (req_too_long) begin
            state_nxt = ST_ERR;
          end else if (req_aligned) begin
            state_nxt = ST_SINGLE;
          end else if (req.byte_offset[ALIGN_W-1:0] != '0) begin
            state_nxt = ST_HEAD;
          end else begin
            state_nxt = ST_BODY;
          end
        end
      end
      ST_ERR: begin
        cmd.too_long = 1'b1;
        cmd.last     = 1'b1;
        if (advance) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SINGLE: begin
        cmd.chunk_offset = cur_r;
        cmd.chunk_length = LEN_W'(left_r);
        cmd.copy_count   = LEN_W'(left_r);
        cmd.last         = 1'b1;
        if (advance) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_HEAD: begin
        cmd.chunk_offset = {cur_r[OFF_W-1:ALIGN_W], {ALIGN_W{1'b0}}};
        cmd.chunk_length = LEN_W'(ALIGN_UNIT);
        cmd.copy_from    = FROM_W'(cur_r[ALIGN_W-1:0]);
        cmd.copy_count   = LEN_W'(step_amt);
        cmd.last         = (left_rem == '0);
        if (advance) begin
          cur_nxt   = cur_sum;
          left_nxt  = left_rem;
          dest_nxt  = dest_sum;
          state_nxt = (left_rem == '0) ? ST_IDLE : ST_BODY;
        end
      end
      ST_BODY: begin
        cmd.chunk_offset = cur_r;
        cmd.chunk_length = LEN_W'(MAX_CHUNK);
        cmd.copy_count   = LEN_W'(step_amt);
        cmd.dest_offset  = dest_r;
        cmd.last         = (left_rem == '0);
        if (advance) begin
          cur_nxt   = cur_sum;
          left_nxt  = left_rem;
          dest_nxt  = dest_sum;
          state_nxt = (left_rem == '0) ? ST_IDLE : ST_BODY;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/arrs_cache.sv -----
// One-entry sector cache and disc limit check for each generated command.
// Depends on arrs_pkg.
module arrs_cache import arrs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  arrs_cmd_t cmd,
  input  logic      fire,
  input  logic      large_disc,
  output logic      issue_read,
  output logic      in_range
);

  logic [OFF_W-1:0] cached_offset_r;
  logic [LEN_W-1:0] cached_length_r;
  logic             miss;

  assign miss = (cmd.chunk_offset != cached_offset_r) ||
                (cmd.chunk_length > cached_length_r);

  // A rejected request carries no read and leaves the cache alone.
  assign issue_read = miss && !cmd.too_long;
  assign in_range   = !cmd.too_long &&
                      ((cmd.chunk_offset < SMALL_LIMIT) ||
                       (large_disc && (cmd.chunk_offset < LARGE_LIMIT)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cached_offset_r <= '0;
      cached_length_r <= '0;
    end else if (fire && issue_read) begin
      cached_offset_r <= cmd.chunk_offset;
      cached_length_r <= cmd.chunk_length;
    end
  end

endmodule

// ----- rtl/aligned_read_request_splitter.sv -----
// Top level of the aligned read request splitter: input handshake, config
// register and output register around the sequencer and cache. Uses arrs_pkg.
//
// Each accepted request word becomes one to 63 command words: an error word
// for an over-long request, a single read for an aligned request of at most
// one chunk, or an optional 32-byte head read followed by 2048-byte reads.
// The sequencer produces one command per cycle through its shared offset
// step while the output is not stalled, and a request keeps the input
// stalled until its final command has moved into the output register.
// The output register lets the next request be taken while the final
// command still waits downstream.
module aligned_read_request_splitter import arrs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  arrs_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output arrs_out_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_data
);

  logic      large_disc_r;
  logic      out_valid_r;
  arrs_out_t out_data_r;
  logic      busy;
  logic      slot_free;
  logic      advance;
  logic      issue_read;
  logic      in_range;
  arrs_cmd_t cmd;

  assign cfg_ready = 1'b1;
  assign in_stall  = busy;
  assign slot_free = !out_valid_r || !out_stall;
  assign advance   = busy && slot_free;

  arrs_cmd_gen u_gen (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (in_valid && !busy),
    .req     (in_data),
    .advance (advance),
    .busy    (busy),
    .cmd     (cmd)
  );

  arrs_cache u_cache (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .fire       (advance),
    .large_disc (large_disc_r),
    .issue_read (issue_read),
    .in_range   (in_range)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      large_disc_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      large_disc_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (slot_free) begin
      out_valid_r <= advance;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r.chunk_offset <= cmd.chunk_offset;
      out_data_r.chunk_length <= cmd.chunk_length;
      out_data_r.issue_read   <= issue_read;
      out_data_r.in_range     <= in_range;
      out_data_r.copy_from    <= cmd.copy_from;
      out_data_r.copy_count   <= cmd.copy_count;
      out_data_r.dest_offset  <= cmd.dest_offset;
      out_data_r.too_long     <= cmd.too_long;
      out_data_r.last         <= cmd.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
